/* src/mfsp_pkg.sv */
// Package for the MIDI file stream parser: phase enum, result kinds, error codes,
// the result and input item record types and shared constants. No dependencies.
package mfsp_pkg;

  localparam int TIME_WIDTH = 48;
  localparam logic [31:0] LEN_LIMIT = 32'h0fff_ffff;

  typedef enum logic [3:0] {
    PH_HDR, PH_TRK, PH_DELTA, PH_STATUS, PH_CH1, PH_CH2,
    PH_META_TYPE, PH_META_LEN, PH_SX_FIRST, PH_SX_LEN,
    PH_META_DATA, PH_SX_DATA, PH_DONE
  } phase_t;

  localparam logic [2:0] K_HEADER  = 3'd0;
  localparam logic [2:0] K_TRACK   = 3'd1;
  localparam logic [2:0] K_CHANNEL = 3'd2;
  localparam logic [2:0] K_META    = 3'd3;
  localparam logic [2:0] K_SYSEX   = 3'd4;
  localparam logic [2:0] K_DATA    = 3'd5;
  localparam logic [2:0] K_ERROR   = 3'd6;
  localparam logic [2:0] K_END     = 3'd7;

  localparam logic [3:0] E_NONE      = 4'd0;
  localparam logic [3:0] E_TRUNC     = 4'd1;
  localparam logic [3:0] E_BAD_MTHD  = 4'd2;
  localparam logic [3:0] E_BAD_MTRK  = 4'd3;
  localparam logic [3:0] E_BAD_DELTA = 4'd4;
  localparam logic [3:0] E_NO_RS     = 4'd5;
  localparam logic [3:0] E_UNKNOWN   = 4'd6;
  localparam logic [3:0] E_NO_EOT    = 4'd7;
  localparam logic [3:0] E_LONG      = 4'd8;

  typedef struct packed {
    logic [2:0]            kind;
    logic [3:0]            error_code;
    logic [TIME_WIDTH-1:0] abs_time;
    logic [3:0]            status_nibble;
    logic [3:0]            channel;
    logic [15:0]           value_a;
    logic [15:0]           value_b;
    logic [15:0]           value_c;
    logic [31:0]           length;
    logic                  last_of_run;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

endpackage

/* src/mfsp_in_if.sv */
// Input channel of the parser: valid/ready with one file byte and its end flag.
// Depends on mfsp_pkg.
interface mfsp_in_if;
  import mfsp_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/mfsp_out_if.sv */
// Output channel of the parser: valid/ready with one result record.
// Depends on mfsp_pkg.
interface mfsp_out_if;
  import mfsp_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/midi_file_stream_parser.sv */
// Standard MIDI file parser, one file byte per request on in_ch.
// Emits header, track, channel, meta, sysex, data byte, error and end results
// on out_ch. Depends on mfsp_pkg, mfsp_in_if and mfsp_out_if.
//
// Usage: feed the file bytes in order on in_ch, with last_byte set on the
// final byte. Each byte gives zero, one or two results; last_of_run marks the
// final result of a byte. A byte is decoded in the cycle it is accepted and
// its results land in a two-entry output queue, so the first result shows in the
// cycle after acceptance. in_ch takes a byte only when the queue, after this
// cycle's pop, is empty, so it has room for two results. With out_ch.ready held
// high the block sustains one byte per cycle while each byte gives at most one
// result; a byte that gives two results holds off the next byte until its second
// result is taken. When out_ch stalls, the queue fills and in_ch.ready drops until
// there is room again. The first error is reported once and then all further
// bytes are consumed with no result, as after the end result, until rst.
// Reset (synchronous, active high) empties the queue and returns the parser
// to expecting the MThd header.
module midi_file_stream_parser (
  input logic        clk,
  input logic        rst,
  mfsp_in_if.sink    in_ch,
  mfsp_out_if.source out_ch
);
  import mfsp_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

  phase_t                phase, phase_next;
  logic [3:0]            field_byte_count, field_byte_count_next;
  logic [31:0]           shift_accumulator, shift_accumulator_next;
  logic [TIME_WIDTH-1:0] track_time, track_time_next;
  logic [31:0]           track_bytes_left, track_bytes_left_next;
  logic [27:0]           payload_bytes_left, payload_bytes_left_next;
  logic [3:0]            running_status, running_status_next;
  logic                  running_status_valid, running_status_valid_next;
  logic [3:0]            running_channel, running_channel_next;
  logic [15:0]           event_hold, event_hold_next;
  logic [15:0]           header_words [3];
  logic [15:0]           header_words_next [3];
  logic                  seen_end_of_track, seen_end_of_track_next;
  logic                  sticky_error, sticky_error_next;

  result_t     res [2];
  logic [1:0]  res_count;
  result_t     queue [2];
  logic [1:0]  fill;
  logic        accept, pop;

  logic [7:0]  b;
  logic        last;
  logic [3:0]  c;
  logic [35:0] v7;
  logic [TIME_WIDTH-1:0] v_ext;
  logic [3:0]  fbc_inc;
  logic [31:0] sa;

  assign b = in_ch.data.data_byte;
  assign last = in_ch.data.last_byte;
  assign c = field_byte_count;
  assign v7 = {shift_accumulator[28:0], b[6:0]};
  assign fbc_inc = c + 4'd1;
  assign v_ext = TIME_WIDTH'(v7[27:0]);

  assign pop = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (fill == 2'd0) || (fill == 2'd1 && pop);
  assign accept = in_ch.valid && in_ch.ready;

  function automatic result_t mk(logic [2:0] k, logic [3:0] e, logic [TIME_WIDTH-1:0] t,
                                 logic [3:0] sn, logic [3:0] ch, logic [15:0] a,
                                 logic [15:0] bb, logic [15:0] cc, logic [31:0] len);
    result_t r;
    r.kind = k; r.error_code = e; r.abs_time = t; r.status_nibble = sn;
    r.channel = ch; r.value_a = a; r.value_b = bb; r.value_c = cc;
    r.length = len; r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic err;
    logic [1:0] n;
    logic one;
    logic [1:0] hi;
    phase_next = phase;
    field_byte_count_next = field_byte_count;
    shift_accumulator_next = shift_accumulator;
    track_time_next = track_time;
    track_bytes_left_next = track_bytes_left;
    payload_bytes_left_next = payload_bytes_left;
    running_status_next = running_status;
    running_status_valid_next = running_status_valid;
    running_channel_next = running_channel;
    event_hold_next = event_hold;
    header_words_next = header_words;
    seen_end_of_track_next = seen_end_of_track;
    sticky_error_next = sticky_error;
    res[0] = '0;
    res[1] = '0;
    n = 2'd0;
    err = 1'b0;
    one = (running_status == 4'hC) || (running_status == 4'hD);
    hi = c[2:1] - 2'd0;
    sa = shift_accumulator;
    if (!sticky_error && phase != PH_DONE) begin
      if (phase == PH_HDR) begin
        if (c < 4'd4) begin
          case (c[1:0])
            2'd0: err = b != 8'h4D;
            2'd1: err = b != 8'h54;
            2'd2: err = b != 8'h68;
            default: err = b != 8'h64;
          endcase
          if (err) begin
            res[0] = mk(K_ERROR, E_BAD_MTHD, track_time, '0, '0, '0, '0, '0, '0);
            n = 2'd1;
          end
        end else if (c < 4'd8) begin
          shift_accumulator_next = {shift_accumulator[23:0], b};
        end else begin
          hi = 2'((c - 4'd8) >> 1);
          header_words_next[hi] = {header_words[hi][7:0], b};
        end
        if (!err) begin
          field_byte_count_next = fbc_inc;
          if (c == 4'd13) begin
            res[0] = mk(K_HEADER, E_NONE, '0, '0, '0, header_words[0], header_words[1],
                        {header_words[2][7:0], b}, shift_accumulator);
            n = 2'd1;
            phase_next = PH_TRK;
            field_byte_count_next = '0;
            shift_accumulator_next = '0;
          end
        end
      end else if (phase == PH_TRK) begin
        if (c < 4'd4) begin
          case (c[1:0])
            2'd0: err = b != 8'h4D;
            2'd1: err = b != 8'h54;
            2'd2: err = b != 8'h72;
            default: err = b != 8'h6B;
          endcase
          if (err) begin
            res[0] = mk(K_ERROR, E_BAD_MTRK, track_time, '0, '0, '0, '0, '0, '0);
            n = 2'd1;
          end
        end else begin
          shift_accumulator_next = {shift_accumulator[23:0], b};
        end
        if (!err) begin
          field_byte_count_next = fbc_inc;
          if (c == 4'd7) begin
            res[0] = mk(K_TRACK, E_NONE, '0, '0, '0, '0, '0, '0,
                        {shift_accumulator[23:0], b});
            n = 2'd1;
            track_bytes_left_next = {shift_accumulator[23:0], b};
            track_time_next = '0;
            running_status_valid_next = 1'b0;
            seen_end_of_track_next = 1'b0;
            phase_next = PH_DELTA;
            field_byte_count_next = '0;
            shift_accumulator_next = '0;
            if ({shift_accumulator[23:0], b} == 32'd0) begin
              res[1] = mk(K_ERROR, E_NO_EOT, '0, '0, '0, '0, '0, '0, '0);
              n = 2'd2;
              err = 1'b1;
            end
          end
        end
      end else begin
        if (track_bytes_left == 32'd0) begin
          res[0] = mk(K_ERROR, E_TRUNC, track_time, '0, '0, '0, '0, '0, '0);
          n = 2'd1;
          err = 1'b1;
        end else begin
          track_bytes_left_next = track_bytes_left - 32'd1;
          case (phase)
            PH_DELTA: begin
              field_byte_count_next = fbc_inc;
              if (v7 > 36'(LEN_LIMIT) || fbc_inc > 4'd5) begin
                res[0] = mk(K_ERROR, E_BAD_DELTA, track_time, '0, '0, '0, '0, '0, '0);
                n = 2'd1;
                err = 1'b1;
              end else begin
                shift_accumulator_next = v7[31:0];
                if (!b[7]) begin
                  if (v_ext > TMAX - track_time) track_time_next = TMAX;
                  else track_time_next = track_time + v_ext;
                  phase_next = PH_STATUS;
                end
              end
            end
            PH_STATUS: begin
              if (!b[7]) begin
                if (!running_status_valid) begin
                  res[0] = mk(K_ERROR, E_NO_RS, track_time, '0, '0, '0, '0, '0, '0);
                  n = 2'd1;
                  err = 1'b1;
                end else if (one) begin
                  res[0] = mk(K_CHANNEL, E_NONE, track_time, running_status,
                              running_channel, 16'(b), '0, '0, '0);
                  n = 2'd1;
                  phase_next = PH_DELTA;
                  field_byte_count_next = '0;
                  shift_accumulator_next = '0;
                end else begin
                  event_hold_next = 16'(b);
                  phase_next = PH_CH2;
                end
              end else if (b < 8'hF0) begin
                running_status_next = b[7:4];
                running_channel_next = b[3:0];
                running_status_valid_next = 1'b1;
                phase_next = PH_CH1;
              end else begin
                running_status_valid_next = 1'b0;
                if (b == 8'hF0) phase_next = PH_SX_FIRST;
                else if (b == 8'hFF) phase_next = PH_META_TYPE;
                else begin
                  res[0] = mk(K_ERROR, E_UNKNOWN, track_time, '0, '0, '0, '0, '0, '0);
                  n = 2'd1;
                  err = 1'b1;
                end
              end
            end
            PH_CH1: begin
              if (one) begin
                res[0] = mk(K_CHANNEL, E_NONE, track_time, running_status,
                            running_channel, 16'(b), '0, '0, '0);
                n = 2'd1;
                phase_next = PH_DELTA;
                field_byte_count_next = '0;
                shift_accumulator_next = '0;
              end else begin
                event_hold_next = 16'(b);
                phase_next = PH_CH2;
              end
            end
            PH_CH2: begin
              res[0] = mk(K_CHANNEL, E_NONE, track_time, running_status,
                          running_channel, event_hold, 16'(b), '0, '0);
              n = 2'd1;
              phase_next = PH_DELTA;
              field_byte_count_next = '0;
              shift_accumulator_next = '0;
            end
            PH_META_TYPE: begin
              event_hold_next = 16'(b);
              if (b == 8'h2F) seen_end_of_track_next = 1'b1;
              phase_next = PH_META_LEN;
              shift_accumulator_next = '0;
            end
            PH_SX_FIRST: begin
              event_hold_next = 16'(b);
              phase_next = PH_SX_LEN;
              shift_accumulator_next = '0;
            end
            PH_META_LEN, PH_SX_LEN: begin
              sa = v7[31:0];
              if (v7 > 36'(LEN_LIMIT)) begin
                res[0] = mk(K_ERROR, E_LONG, track_time, '0, '0, '0, '0, '0, '0);
                n = 2'd1;
                err = 1'b1;
              end else begin
                shift_accumulator_next = sa;
                if (!b[7]) begin
                  if ((phase == PH_SX_LEN && sa == 32'd0) || sa > track_bytes_left_next) begin
                    res[0] = mk(K_ERROR, E_TRUNC, track_time, '0, '0, '0, '0, '0, '0);
                    n = 2'd1;
                    err = 1'b1;
                  end else begin
                    res[0] = mk((phase == PH_META_LEN) ? K_META : K_SYSEX, E_NONE,
                                track_time, '0, '0, '0, '0, event_hold, sa);
                    n = 2'd1;
                    payload_bytes_left_next = sa[27:0];
                    if (phase == PH_META_LEN) begin
                      if (sa == 32'd0) begin
                        phase_next = PH_DELTA;
                        field_byte_count_next = '0;
                        shift_accumulator_next = '0;
                      end else phase_next = PH_META_DATA;
                    end else phase_next = PH_SX_DATA;
                  end
                end
              end
            end
            PH_META_DATA, PH_SX_DATA: begin
              if (phase == PH_META_DATA || payload_bytes_left > 28'd1) begin
                res[0] = mk(K_DATA, E_NONE, track_time, '0, '0, 16'(b), '0, '0, '0);
                n = 2'd1;
              end
              if (payload_bytes_left <= 28'd1) begin
                payload_bytes_left_next = '0;
                phase_next = PH_DELTA;
                field_byte_count_next = '0;
                shift_accumulator_next = '0;
              end else payload_bytes_left_next = payload_bytes_left - 28'd1;
            end
            default: ;
          endcase
          if (!err && track_bytes_left_next == 32'd0) begin
            if (phase_next == PH_DELTA && field_byte_count_next == 4'd0) begin
              if (seen_end_of_track_next) begin
                phase_next = PH_TRK;
                shift_accumulator_next = '0;
              end else begin
                res[n[0]] = mk(K_ERROR, E_NO_EOT, track_time_next, '0, '0, '0, '0, '0, '0);
                n = n + 2'd1;
                err = 1'b1;
              end
            end else begin
              res[n[0]] = mk(K_ERROR, E_TRUNC, track_time_next, '0, '0, '0, '0, '0, '0);
              n = n + 2'd1;
              err = 1'b1;
            end
          end
        end
      end
      if (!err && last) begin
        if (phase_next == PH_TRK && field_byte_count_next == 4'd0) begin
          res[n[0]] = mk(K_END, E_NONE, '0, '0, '0, '0, '0, '0, '0);
          phase_next = PH_DONE;
        end else begin
          res[n[0]] = mk(K_ERROR, E_TRUNC, track_time_next, '0, '0, '0, '0, '0, '0);
          err = 1'b1;
        end
        n = n + 2'd1;
      end
      if (err) sticky_error_next = 1'b1;
    end
    if (n != 2'd0) res[n[1] ? 1 : 0].last_of_run = 1'b1;
    res_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;
      field_byte_count <= '0;
      shift_accumulator <= '0;
      track_time <= '0;
      track_bytes_left <= '0;
      payload_bytes_left <= '0;
      running_status <= '0;
      running_status_valid <= 1'b0;
      running_channel <= '0;
      event_hold <= '0;
      header_words <= '{default: '0};
      seen_end_of_track <= 1'b0;
      sticky_error <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      field_byte_count <= field_byte_count_next;
      shift_accumulator <= shift_accumulator_next;
      track_time <= track_time_next;
      track_bytes_left <= track_bytes_left_next;
      payload_bytes_left <= payload_bytes_left_next;
      running_status <= running_status_next;
      running_status_valid <= running_status_valid_next;
      running_channel <= running_channel_next;
      event_hold <= event_hold_next;
      header_words <= header_words_next;
      seen_end_of_track <= seen_end_of_track_next;
      sticky_error <= sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    logic [1:0] base;
    logic [1:0] add;
    base = pop ? fill - 2'd1 : fill;
    add = accept ? res_count : 2'd0;
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= base + add;
    end
    if (base == 2'd0 && add != 2'd0) queue[0] <= res[0];
    else if (pop) queue[0] <= queue[1];
    if (add == 2'd2) queue[1] <= res[1];
    else if (add != 2'd0 && base != 2'd0) queue[1] <= res[0];
  end

  assign out_ch.valid = fill != 2'd0;
  assign out_ch.data = queue[0];

endmodule

/* tb/midi_file_stream_parser_tb.sv */
// Testbench for midi_file_stream_parser: builds one MIDI file byte stream with
// random tracks and a random ending, predicts every result and checks it.
// Depends on mfsp_pkg, mfsp_in_if, mfsp_out_if and the parser RTL.
`timescale 1ns / 1ps

module midi_file_stream_parser_tb;
  import mfsp_pkg::*;

  localparam logic [31:0] HDR_ID = 32'h4D546864;
  localparam logic [31:0] TRK_ID = 32'h4D54726B;
  localparam logic [47:0] TIME_MAX = {48{1'b1}};
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mfsp_in_if in_ch();
  mfsp_out_if out_ch();

  midi_file_stream_parser uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  item_t       file_bytes[$];
  logic [7:0]  track_body[$];
  result_t     expected_results[$];
  int          failures = 0;
  int          cycles = 0;

  // parser state mirror
  phase_t      ph;
  logic [3:0]  fcnt;
  logic [31:0] acc;
  logic [47:0] ttime;
  logic [31:0] tleft;
  logic [31:0] pleft;
  logic [3:0]  rs_nib;
  bit          rs_valid;
  logic [3:0]  rs_chan;
  logic [15:0] hold;
  logic [15:0] hdr_words[3];
  bit          eot_seen;
  bit          err_seen;
  int          nres;

  task automatic emit(logic [2:0] kind, logic [3:0] code, logic [47:0] t, logic [3:0] sn,
                      logic [3:0] ch, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                      logic [31:0] len);
    result_t r;
    if (nres < 2) begin
      r.kind = kind;
      r.error_code = code;
      r.abs_time = t;
      r.status_nibble = sn;
      r.channel = ch;
      r.value_a = a;
      r.value_b = b;
      r.value_c = c;
      r.length = len;
      r.last_of_run = 1'b0;
      expected_results.push_back(r);
      nres++;
    end
  endtask

  task automatic raise(logic [3:0] code);
    emit(K_ERROR, code, ttime, 0, 0, 0, 0, 0, 0);
    err_seen = 1'b1;
  endtask

  task automatic to_delta();
    ph = PH_DELTA;
    fcnt = 0;
    acc = 0;
  endtask

  task automatic channel_event(logic [15:0] a, logic [15:0] b);
    emit(K_CHANNEL, E_NONE, ttime, rs_nib, rs_chan, a, b, 0, 0);
    to_delta();
  endtask

  function automatic bit one_param(logic [3:0] nib);
    return nib == 4'hC || nib == 4'hD;
  endfunction

  task automatic body_byte(logic [7:0] b);
    logic [63:0] v;
    v = ({32'b0, acc} << 7) | {57'b0, b[6:0]};
    case (ph)
      PH_DELTA: begin
        fcnt = fcnt + 4'd1;
        if (v > {32'b0, LEN_LIMIT} || fcnt > 4'd5) begin
          raise(E_BAD_DELTA);
        end else begin
          acc = v[31:0];
          if (!b[7]) begin
            if (v[47:0] > TIME_MAX - ttime) ttime = TIME_MAX;
            else ttime = ttime + v[47:0];
            ph = PH_STATUS;
          end
        end
      end
      PH_STATUS: begin
        if (b < 8'h80) begin
          if (!rs_valid) raise(E_NO_RS);
          else if (one_param(rs_nib)) channel_event(16'(b), 0);
          else begin
            hold = 16'(b);
            ph = PH_CH2;
          end
        end else if (b < 8'hF0) begin
          rs_nib = b[7:4];
          rs_chan = b[3:0];
          rs_valid = 1'b1;
          ph = PH_CH1;
        end else begin
          rs_valid = 1'b0;
          if (b == 8'hF0) ph = PH_SX_FIRST;
          else if (b == 8'hFF) ph = PH_META_TYPE;
          else raise(E_UNKNOWN);
        end
      end
      PH_CH1: begin
        if (one_param(rs_nib)) channel_event(16'(b), 0);
        else begin
          hold = 16'(b);
          ph = PH_CH2;
        end
      end
      PH_CH2: channel_event(hold, 16'(b));
      PH_META_TYPE: begin
        hold = 16'(b);
        if (b == 8'h2F) eot_seen = 1'b1;
        ph = PH_META_LEN;
        acc = 0;
      end
      PH_SX_FIRST: begin
        hold = 16'(b);
        ph = PH_SX_LEN;
        acc = 0;
      end
      PH_META_LEN, PH_SX_LEN: begin
        if (v > {32'b0, LEN_LIMIT}) begin
          raise(E_LONG);
        end else begin
          acc = v[31:0];
          if (!b[7]) begin
            if (ph == PH_SX_LEN && acc == 0) raise(E_TRUNC);
            else if (acc > tleft) raise(E_TRUNC);
            else begin
              emit(ph == PH_META_LEN ? K_META : K_SYSEX, E_NONE, ttime, 0, 0, 0, 0,
                   hold, acc);
              pleft = acc;
              if (ph == PH_META_LEN) begin
                if (pleft == 0) to_delta();
                else ph = PH_META_DATA;
              end else begin
                ph = PH_SX_DATA;
              end
            end
          end
        end
      end
      PH_META_DATA, PH_SX_DATA: begin
        if (ph == PH_META_DATA || pleft > 1)
          emit(K_DATA, E_NONE, ttime, 0, 0, 16'(b), 0, 0, 0);
        if (pleft > 0) pleft = pleft - 32'd1;
        if (pleft == 0) to_delta();
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(logic [7:0] b, logic last);
    logic [3:0] c;
    int i;
    result_t r;
    c = fcnt;
    nres = 0;
    if (!err_seen && ph != PH_DONE) begin
      if (ph == PH_HDR) begin
        if (c < 4) begin
          if (b != HDR_ID[31 - 8 * c -: 8]) raise(E_BAD_MTHD);
        end else if (c < 8) begin
          acc = {acc[23:0], b};
        end else begin
          i = ((c - 8) >> 1) % 3;
          hdr_words[i] = {hdr_words[i][7:0], b};
        end
        if (!err_seen) begin
          fcnt = c + 4'd1;
          if (c == 13) begin
            emit(K_HEADER, E_NONE, 0, 0, 0, hdr_words[0], hdr_words[1], hdr_words[2], acc);
            ph = PH_TRK;
            fcnt = 0;
            acc = 0;
          end
        end
      end else if (ph == PH_TRK) begin
        if (c < 4) begin
          if (b != TRK_ID[31 - 8 * c -: 8]) raise(E_BAD_MTRK);
        end else begin
          acc = {acc[23:0], b};
        end
        if (!err_seen) begin
          fcnt = c + 4'd1;
          if (c == 7) begin
            emit(K_TRACK, E_NONE, 0, 0, 0, 0, 0, 0, acc);
            tleft = acc;
            ttime = 0;
            rs_valid = 1'b0;
            eot_seen = 1'b0;
            to_delta();
            if (tleft == 0) raise(E_NO_EOT);
          end
        end
      end else if (tleft == 0) begin
        raise(E_TRUNC);
      end else begin
        tleft = tleft - 32'd1;
        body_byte(b);
        if (!err_seen && tleft == 0) begin
          if (ph == PH_DELTA && fcnt == 0) begin
            if (eot_seen) begin
              ph = PH_TRK;
              fcnt = 0;
              acc = 0;
            end else begin
              raise(E_NO_EOT);
            end
          end else begin
            raise(E_TRUNC);
          end
        end
      end
      if (!err_seen && last) begin
        if (ph == PH_TRK && fcnt == 0) begin
          emit(K_END, E_NONE, 0, 0, 0, 0, 0, 0, 0);
          ph = PH_DONE;
        end else begin
          raise(E_TRUNC);
        end
      end
      if (nres > 0) begin
        r = expected_results.pop_back();
        r.last_of_run = 1'b1;
        expected_results.push_back(r);
      end
    end
  endtask

  // stream building
  task automatic add_byte(logic [7:0] b, logic last);
    item_t it;
    it.data_byte = b;
    it.last_byte = last;
    file_bytes.push_back(it);
  endtask

  task automatic add_vlq(logic [31:0] v);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    for (int k = n - 1; k >= 0; k--)
      track_body.push_back({k != 0, 7'((v >> (7 * k)) & 32'h7F)});
  endtask

  task automatic add_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) add_vlq($urandom_range(0, 127));
    else if (r < 85) add_vlq($urandom_range(128, 32'h3FFF));
    else if (r < 92) add_vlq($urandom & 32'h0FFF_FFFF);
    else if (r < 96) add_vlq(LEN_LIMIT);
    else begin
      track_body.push_back(8'h80);
      track_body.push_back(8'h80);
      add_vlq($urandom_range(0, 127));
    end
  endtask

  task automatic add_events(int count);
    bit prev_channel;
    logic [7:0] st;
    int len;
    prev_channel = 0;
    st = 8'h90;
    for (int e = 0; e < count; e++) begin
      add_delta();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if (prev_channel && $urandom_range(0, 2) == 0) begin
            track_body.push_back(8'($urandom_range(0, 127)));
          end else begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            track_body.push_back(st);
            track_body.push_back(8'($urandom_range(0, 255)));
          end
          if (!one_param(st[7:4])) track_body.push_back(8'($urandom_range(0, 255)));
          prev_channel = 1;
        end
        6, 7: begin
          track_body.push_back(8'hFF);
          track_body.push_back(8'($urandom_range(0, 46)));
          len = $urandom_range(0, 4);
          add_vlq(len);
          repeat (len) track_body.push_back(8'($urandom_range(0, 255)));
          prev_channel = 0;
        end
        default: begin
          track_body.push_back(8'hF0);
          track_body.push_back(8'($urandom_range(0, 255)));
          len = $urandom_range(1, 4);
          add_vlq(len);
          repeat (len) track_body.push_back(8'($urandom_range(0, 255)));
          prev_channel = 0;
        end
      endcase
    end
  endtask

  task automatic add_end_of_track();
    track_body.push_back(8'h00);
    track_body.push_back(8'hFF);
    track_body.push_back(8'h2F);
    track_body.push_back(8'h00);
  endtask

  task automatic flush_track(logic [31:0] tag, logic [31:0] len, int keep);
    for (int k = 3; k >= 0; k--) add_byte(tag[8 * k +: 8], 1'b0);
    for (int k = 3; k >= 0; k--) add_byte(len[8 * k +: 8], 1'b0);
    for (int k = 0; k < keep && k < track_body.size(); k++) add_byte(track_body[k], 1'b0);
    track_body.delete();
  endtask

  task automatic build_file();
    logic [31:0] hlen;
    int ending;
    item_t it;
    hlen = $urandom;
    for (int k = 3; k >= 0; k--) add_byte(HDR_ID[8 * k +: 8], 1'b0);
    for (int k = 3; k >= 0; k--) add_byte(hlen[8 * k +: 8], 1'b0);
    repeat (6) add_byte(8'($urandom_range(0, 255)), 1'b0);
    ending = $urandom_range(0, 9);
    if (ending == 9) begin
      it = file_bytes[$urandom_range(0, 3)];
      file_bytes[$urandom_range(0, 3)].data_byte = ~it.data_byte;
    end
    // opening track: delta and status extremes, running status on the 9x, Bx, Cx, Dx
    // and Ex channel messages, empty meta, one-byte sysex (terminator only)
    track_body = '{8'h00, 8'h80, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
                   8'h90, 8'h3C, 8'h7F, 8'h00, 8'h00, 8'h3C, 8'h00};
    for (int n = 8'hA; n <= 8'hE; n++) begin
      track_body.push_back(8'h00);
      track_body.push_back({n[3:0], 4'hF});
      track_body.push_back(8'hFF);
      if (!one_param(n[3:0])) track_body.push_back(8'h00);
      track_body.push_back(8'h01);
      track_body.push_back(8'h7F);
      if (!one_param(n[3:0])) track_body.push_back(8'h80);
    end
    track_body = {track_body, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'hF0, 8'h7E, 8'h01, 8'hF7};
    add_end_of_track();
    flush_track(TRK_ID, track_body.size(), track_body.size());
    while (file_bytes.size() < 380) begin
      add_events($urandom_range(4, 20));
      add_end_of_track();
      flush_track(TRK_ID, track_body.size(), track_body.size());
    end
    case (ending)
      0, 1, 2: add_byte(8'h4D, 1'b0);
      3: begin
        add_events(5);
        flush_track(TRK_ID, track_body.size(), track_body.size());
      end
      4: begin
        repeat ($urandom_range(1, 30)) track_body.push_back(8'($urandom_range(0, 255)));
        flush_track(TRK_ID, track_body.size(), track_body.size());
      end
      5: begin
        repeat ($urandom_range(1, 30)) track_body.push_back(8'($urandom_range(0, 255)));
        flush_track(TRK_ID, $urandom_range(0, 40), track_body.size());
      end
      6: flush_track(32'h4D54_7278, 0, 0);
      7: begin
        add_events(6);
        add_end_of_track();
        flush_track(TRK_ID, track_body.size(), track_body.size() / 2);
      end
      default: begin
        track_body.push_back(8'h00);
        track_body.push_back(8'hFF);
        track_body.push_back(8'h01);
        repeat (5) track_body.push_back(8'hFF);
        flush_track(TRK_ID, track_body.size(), track_body.size());
      end
    endcase
    if (ending <= 2) begin
      void'(file_bytes.pop_back());
      it = file_bytes.pop_back();
      it.last_byte = 1'b1;
      file_bytes.push_back(it);
      if (ending == 2)
        repeat (10) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      it = file_bytes.pop_back();
      it.last_byte = 1'b1;
      file_bytes.push_back(it);
    end
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int  send_gap = 0;
  int  recv_gap = 0;
  int  recv_pick = 0;
  bit  send_calm = 0;
  bit  recv_calm = 0;
  item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (file_bytes.size() > 0) begin
        next_item = file_bytes.pop_front();
        predict_byte(next_item.data_byte, next_item.last_byte);
        in_ch.data <= next_item;
        in_ch.valid <= 1'b1;
        if ($urandom_range(0, 49) == 0) send_calm <= ~send_calm;
        send_gap <= pick_gap(send_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      if ($urandom_range(0, 49) == 0) recv_calm <= ~recv_calm;
      recv_pick = pick_gap(recv_calm);
      recv_gap <= recv_pick;
      out_ch.ready <= (recv_pick == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  result_t want;

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result kind=%0d code=%0d", $time, out_ch.data.kind,
                 out_ch.data.error_code);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.kind !== want.kind || out_ch.data.error_code !== want.error_code ||
            out_ch.data.abs_time !== want.abs_time ||
            out_ch.data.status_nibble !== want.status_nibble ||
            out_ch.data.channel !== want.channel || out_ch.data.value_a !== want.value_a ||
            out_ch.data.value_b !== want.value_b || out_ch.data.value_c !== want.value_c ||
            out_ch.data.length !== want.length ||
            out_ch.data.last_of_run !== want.last_of_run) begin
          failures++;
          $display("%0t: result mismatch expected %h actual %h", $time, want, out_ch.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("midi_file_stream_parser test failed");
      $finish;
    end
  end

  initial begin
    ph = PH_HDR;
    fcnt = 0;
    acc = 0;
    ttime = 0;
    tleft = 0;
    pleft = 0;
    rs_nib = 0;
    rs_valid = 0;
    rs_chan = 0;
    hold = 0;
    hdr_words = '{16'h0, 16'h0, 16'h0};
    eot_seen = 0;
    err_seen = 0;
    build_file();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (file_bytes.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("midi_file_stream_parser test passed");
    end else begin
      $display("midi_file_stream_parser test failed");
    end
    $finish;
  end

endmodule
